>>> design/iptc_pkg.sv
package iptc_pkg;

  localparam logic [7:0] Marker = 8'h1C;
  localparam logic [15:0] ExtFlag = 16'h8000;
  localparam logic [15:0] ExtCountMask = 16'h7FFF;
  localparam logic [14:0] ExtCountMax = 15'd4;
  localparam logic [31:0] MinDatasetBytes = 32'd5;

  localparam logic [1:0] KindHeader = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusUnsupported = 2'd1;
  localparam logic [1:0] StatusMalformed = 2'd2;
  localparam logic [1:0] StatusLimit = 2'd3;

  localparam logic [1:0] RegMaxCount = 2'd0;
  localparam logic [1:0] RegMaxLength = 2'd1;
  localparam logic [1:0] RegMaxTotal = 2'd2;

  typedef struct packed {
    logic [31:0] max_count;
    logic [31:0] max_length;
    logic [31:0] total_cap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  record;
    logic [7:0]  dataset;
    logic [31:0] length;
    logic [31:0] index;
    logic [7:0]  pbyte;
    logic        pend;
    logic [1:0]  status;
    logic [31:0] decoded;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } res_pair_t;

endpackage

>>> design/iptc_iim_dataset_parser.sv
// Channel   Handshake                  Beat contents
// data      data_valid / data_stall    data_byte, first_of_buffer, buffer_length
// result    result_valid / result_stall header, payload byte or end status
// config    cfg_write                  cfg_index, cfg_data
//
// One byte is accepted per cycle while data_stall is low; it is decoded in
// the cycle after it is taken. A byte gives zero, one or two result beats,
// which are registered into an eight-entry queue and leave from its head.
// The input stalls when the queue holds more than six beats, counting the byte
// in decode as two.
// Reset is synchronous, clears the parser and the queue and lifts all limits.
module iptc_iim_dataset_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_of_buffer,
  input  logic [31:0] buffer_length,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  record_number,
  output logic [7:0]  dataset_number,
  output logic [31:0] payload_length,
  output logic [31:0] dataset_index,
  output logic [7:0]  payload_byte,
  output logic        payload_end,
  output logic [1:0]  final_status,
  output logic [31:0] datasets_decoded,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  iptc_pkg::cfg_t      cfg;
  iptc_pkg::res_pair_t res;
  iptc_pkg::result_t   head;
  logic                busy;
  logic                take;
  logic [3:0]          count;
  logic [4:0]          committed;

  assign committed = {1'b0, count} + {3'd0, busy, 1'b0};
  assign data_stall = (committed > 5'd6);
  assign take = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_count <= 32'hFFFF_FFFF;
      cfg.max_length <= 32'hFFFF_FFFF;
      cfg.total_cap <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        iptc_pkg::RegMaxCount: cfg.max_count <= cfg_data;
        iptc_pkg::RegMaxLength: cfg.max_length <= cfg_data;
        iptc_pkg::RegMaxTotal: cfg.total_cap <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  iptc_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .take(take),
    .data_byte(data_byte),
    .first_of_buffer(first_of_buffer),
    .buffer_length(buffer_length),
    .cfg(cfg),
    .busy(busy),
    .res(res)
  );

  iptc_rfifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(res),
    .pop(result_valid && !result_stall),
    .not_empty(result_valid),
    .count(count),
    .head(head)
  );

  assign result_kind = head.kind;
  assign record_number = head.record;
  assign dataset_number = head.dataset;
  assign payload_length = head.length;
  assign dataset_index = head.index;
  assign payload_byte = head.pbyte;
  assign payload_end = head.pend;
  assign final_status = head.status;
  assign datasets_decoded = head.decoded;
  assign last_of_run = head.last;

endmodule

>>> design/iptc_core.sv
module iptc_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               first_of_buffer,
  input  logic [31:0]        buffer_length,
  input  iptc_pkg::cfg_t     cfg,
  output logic               busy,
  output iptc_pkg::res_pair_t res
);

  localparam logic [63:0] LenMaxWide = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam logic [31:0] LenMax = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF : LenMaxWide[31:0];

  typedef enum logic [2:0] {
    PhIdle, PhMarker, PhRecord, PhDataset, PhLenHi, PhLenLo, PhExt, PhPayload
  } phase_t;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_first;
  logic [31:0] s1_len;

  phase_t      phase, phase_next;
  logic [31:0] rem, rem_next;
  logic [7:0]  record, record_next;
  logic [7:0]  dataset, dataset_next;
  logic [7:0]  len_hi, len_hi_next;
  logic [2:0]  ext_left, ext_left_next;
  logic [31:0] acc, acc_next;
  logic [31:0] plen, plen_next;
  logic [31:0] prem, prem_next;
  logic [32:0] summed, summed_next;
  logic [31:0] counter, counter_next;
  logic [1:0]  err, err_next;

  logic        fin_go;
  logic [31:0] fin_raw;
  logic [31:0] fin_v;
  logic [32:0] sum_new;
  logic [15:0] len16;
  logic [14:0] ext_cnt;
  logic [31:0] acc_shift;
  logic [31:0] cur_rem;
  logic        active;
  logic        main_v;
  logic        st_v;
  iptc_pkg::result_t main_r;
  iptc_pkg::result_t st_r;

  assign busy = s1_valid;
  assign len16 = {len_hi, s1_byte};
  assign ext_cnt = len16[14:0] & iptc_pkg::ExtCountMask[14:0];
  assign acc_shift = {acc[23:0], s1_byte};
  assign fin_v = (fin_raw > LenMax) ? LenMax : fin_raw;
  assign sum_new = summed + {1'b0, fin_v};
  assign cur_rem = s1_first ? s1_len : rem;
  assign active = s1_valid && (s1_first ? (s1_len != 32'd0) : (phase != PhIdle));

  always_comb begin
    phase_next = phase;
    rem_next = rem;
    record_next = record;
    dataset_next = dataset;
    len_hi_next = len_hi;
    ext_left_next = ext_left;
    acc_next = acc;
    plen_next = plen;
    prem_next = prem;
    summed_next = summed;
    counter_next = counter;
    err_next = err;
    fin_go = 1'b0;
    fin_raw = '0;
    main_v = 1'b0;
    main_r = '0;
    st_v = 1'b0;

    if (s1_valid && s1_first) begin
      record_next = '0;
      dataset_next = '0;
      len_hi_next = '0;
      ext_left_next = '0;
      acc_next = '0;
      plen_next = '0;
      prem_next = '0;
      summed_next = '0;
      counter_next = '0;
      err_next = iptc_pkg::StatusOk;
      if (s1_len == 32'd0) begin
        phase_next = PhIdle;
        rem_next = '0;
        err_next = iptc_pkg::StatusUnsupported;
        st_v = 1'b1;
      end else begin
        phase_next = PhMarker;
        if (s1_byte != iptc_pkg::Marker) begin
          err_next = iptc_pkg::StatusUnsupported;
        end else if (cfg.total_cap != 32'd0 && s1_len > cfg.total_cap) begin
          err_next = iptc_pkg::StatusLimit;
        end else if (cfg.max_count == 32'd0) begin
          err_next = iptc_pkg::StatusLimit;
        end else if (s1_len < iptc_pkg::MinDatasetBytes) begin
          err_next = iptc_pkg::StatusMalformed;
        end else begin
          phase_next = PhRecord;
        end
      end
    end else if (active && err == iptc_pkg::StatusOk) begin
      unique case (phase)
        PhMarker: begin
          if (counter >= cfg.max_count) begin
            err_next = iptc_pkg::StatusLimit;
          end else if (rem < iptc_pkg::MinDatasetBytes) begin
            err_next = iptc_pkg::StatusMalformed;
          end else if (s1_byte != iptc_pkg::Marker) begin
            err_next = iptc_pkg::StatusMalformed;
          end else begin
            phase_next = PhRecord;
          end
        end
        PhRecord: begin
          record_next = s1_byte;
          phase_next = PhDataset;
        end
        PhDataset: begin
          dataset_next = s1_byte;
          phase_next = PhLenHi;
        end
        PhLenHi: begin
          len_hi_next = s1_byte;
          phase_next = PhLenLo;
        end
        PhLenLo: begin
          if ((len16 & iptc_pkg::ExtFlag) == 16'd0) begin
            fin_go = 1'b1;
            fin_raw = {16'd0, len16};
          end else if (ext_cnt == 15'd0 || ext_cnt > iptc_pkg::ExtCountMax) begin
            err_next = iptc_pkg::StatusMalformed;
          end else if ({17'd0, ext_cnt} >= rem) begin
            err_next = iptc_pkg::StatusMalformed;
          end else begin
            ext_left_next = ext_cnt[2:0];
            acc_next = '0;
            phase_next = PhExt;
          end
        end
        PhExt: begin
          acc_next = acc_shift;
          ext_left_next = ext_left - 3'd1;
          if (ext_left == 3'd1) begin
            fin_go = 1'b1;
            fin_raw = acc_shift;
          end
        end
        PhPayload: begin
          prem_next = prem - 32'd1;
          main_v = 1'b1;
          main_r.kind = iptc_pkg::KindPayload;
          main_r.record = record;
          main_r.dataset = dataset;
          main_r.length = plen;
          main_r.index = counter - 32'd1;
          main_r.pbyte = s1_byte;
          main_r.pend = (prem == 32'd1);
          if (prem == 32'd1) begin
            phase_next = PhMarker;
          end
        end
        default: begin
        end
      endcase

      if (fin_go) begin
        if (fin_v > cfg.max_length) begin
          err_next = iptc_pkg::StatusLimit;
        end else if (fin_v >= rem) begin
          err_next = iptc_pkg::StatusMalformed;
        end else begin
          summed_next = sum_new;
          if (cfg.total_cap != 32'd0 && sum_new > {1'b0, cfg.total_cap}) begin
            err_next = iptc_pkg::StatusLimit;
          end else begin
            plen_next = fin_v;
            prem_next = fin_v;
            counter_next = counter + 32'd1;
            phase_next = (fin_v == 32'd0) ? PhMarker : PhPayload;
            main_v = 1'b1;
            main_r.kind = iptc_pkg::KindHeader;
            main_r.record = record;
            main_r.dataset = dataset;
            main_r.length = fin_v;
            main_r.index = counter;
          end
        end
      end
    end

    if (active) begin
      rem_next = cur_rem - 32'd1;
      if (cur_rem <= 32'd1) begin
        st_v = 1'b1;
        phase_next = PhIdle;
      end
    end
  end

  always_comb begin
    st_r = '0;
    st_r.kind = iptc_pkg::KindStatus;
    st_r.status = err_next;
    st_r.decoded = counter_next;
    st_r.last = 1'b1;
    res = '0;
    if (main_v) begin
      res.valid0 = 1'b1;
      res.r0 = main_r;
      res.r0.last = !st_v;
      res.valid1 = st_v;
      res.r1 = st_r;
    end else begin
      res.valid0 = st_v;
      res.r0 = st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      phase <= PhIdle;
      rem <= '0;
      record <= '0;
      dataset <= '0;
      len_hi <= '0;
      ext_left <= '0;
      acc <= '0;
      plen <= '0;
      prem <= '0;
      summed <= '0;
      counter <= '0;
      err <= iptc_pkg::StatusOk;
    end else begin
      s1_valid <= take;
      if (s1_valid) begin
        phase <= phase_next;
        rem <= rem_next;
        record <= record_next;
        dataset <= dataset_next;
        len_hi <= len_hi_next;
        ext_left <= ext_left_next;
        acc <= acc_next;
        plen <= plen_next;
        prem <= prem_next;
        summed <= summed_next;
        counter <= counter_next;
        err <= err_next;
      end
    end
    if (take) begin
      s1_byte <= data_byte;
      s1_first <= first_of_buffer;
      s1_len <= buffer_length;
    end
  end

  a_second_is_status: assert property (@(posedge clk) disable iff (rst)
    res.valid1 |-> (res.valid0 && res.r1.kind == iptc_pkg::KindStatus))
    else $error("second result of a byte is not a status");

  a_status_idles: assert property (@(posedge clk) disable iff (rst)
    (res.valid0 && res.r0.last && res.r0.kind != iptc_pkg::KindStatus
     && !res.valid1) |=> phase != PhIdle || $past(s1_first))
    else $error("parser went idle without a status beat");

  a_header_counts: assert property (@(posedge clk) disable iff (rst)
    (res.valid0 && res.r0.kind == iptc_pkg::KindHeader) |=> counter == $past(counter) + 32'd1)
    else $error("header beat without a dataset count step");

endmodule

>>> design/iptc_rfifo.sv
module iptc_rfifo (
  input  logic                clk,
  input  logic                rst,
  input  iptc_pkg::res_pair_t push,
  input  logic                pop,
  output logic                not_empty,
  output logic [3:0]          count,
  output iptc_pkg::result_t   head
);

  localparam int Depth = 8;

  iptc_pkg::result_t mem [Depth];
  logic [2:0] wptr;
  logic [2:0] rptr;
  logic [2:0] wptr_b;
  logic [1:0] n_push;

  assign not_empty = (count != 4'd0);
  assign head = mem[rptr];
  assign wptr_b = wptr + {2'd0, push.valid0};
  assign n_push = {1'b0, push.valid0} + {1'b0, push.valid1};

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + {1'b0, n_push};
      rptr <= rptr + {2'd0, pop};
      count <= count + {2'd0, n_push} - {3'd0, pop};
    end
    if (push.valid0) begin
      mem[wptr] <= push.r0;
    end
    if (push.valid1) begin
      mem[wptr_b] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 4'(Depth))
    else $error("result queue overflow");

endmodule
